// ===== rtl/mch_pkg.sv =====
// ----------------------------------------------------------------------------
// mch_pkg: shared types and constants for the calibrated heading block
// Widths, scale constants, register indexes, unit handshakes and the
// whole-degree sine and cosine tables used by the heading search.
// ----------------------------------------------------------------------------
package mch_pkg;

  localparam int RAW_W   = 16;   // raw axis sample
  localparam int CAL_W   = 14;   // calibrated axis value
  localparam int MM_W    = 15;   // running minimum and maximum
  localparam int HDG_W   = 9;    // heading in degrees
  localparam int SPAN_W  = 14;   // cal_min_span register
  localparam int OSPAN_W = 10;   // cal_out_span register
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int DIV_NW = 25;    // divider dividend and quotient
  localparam int DIV_DW = 14;    // divider divisor
  localparam int DIV_CW = 5;     // divider step counter

  localparam int TAB_N  = 45;    // table entries, 0..44 degrees
  localparam int TAB_AW = 6;     // table index, also holds 45
  localparam int TAB_W  = 48;    // Q48 fraction bits
  localparam int TAB_HW = 24;    // half of a table word
  localparam int ACC_W  = 64;

  // Milligauss scaling: raw * 1000 / 6842 is taken as a multiply by the
  // rounded-up reciprocal in Q27 and a shift. The rounding error stays far
  // below one step of the true quotient for magnitudes up to 2^15.
  localparam int SCL_RW      = 25;
  localparam int SCL_PW      = RAW_W + SCL_RW;
  localparam int SCALE_SHIFT = 27;
  localparam logic [SCL_RW-1:0]   SCALE_RECIP = 25'd19616739;

  localparam logic [3:0]          NEW_DATA_MASK = 4'hf;
  localparam logic [MM_W-1:0]     MIN_RESET = 15'sd10000;
  localparam logic [MM_W-1:0]     MAX_RESET = -15'sd10000;
  localparam logic [SPAN_W-1:0]   MIN_SPAN_RESET = 14'd300;
  localparam logic [OSPAN_W-1:0]  OUT_SPAN_RESET = 10'd800;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_SPAN = 8'd1;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                    done;
    logic signed [HDG_W-1:0] deg;
  } hdg_rsp_t;

  localparam real PI_R = 3.14159265358979323846;

  // Floor of sin(k degrees) in Q48, evaluated at elaboration.
  function automatic logic [TAB_W-1:0] sin_q48(input int k);
    real r;
    longint v;
    r = $sin(k * PI_R / 180.0) * (2.0 ** 48);
    v = longint'($floor(r));
    return v[TAB_W-1:0];
  endfunction

  function automatic logic [TAB_W-1:0] cos_q48(input int k);
    real r;
    longint v;
    r = $cos(k * PI_R / 180.0) * (2.0 ** 48);
    v = longint'($floor(r));
    return v[TAB_W-1:0];
  endfunction

endpackage

// ===== rtl/mch_div.sv =====
// ----------------------------------------------------------------------------
// mch_div: shared restoring divider
// Unsigned division, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module mch_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mch_pkg::div_req_t req,
  output mch_pkg::div_rsp_t rsp
);
  import mch_pkg::*;

  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] dsr_r;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW+1:0] trial;

  always_comb begin
    shifted  = {rem_r, quo_r[DIV_NW-1]};
    trial    = {1'b0, shifted} - {2'b00, dsr_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_NW-2:0], ~trial[DIV_DW+1]};
      rem_nxt = trial[DIV_DW+1] ? shifted[DIV_DW-1:0] : trial[DIV_DW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dsr_r <= req.divisor;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/mch_hdg.sv =====
// ----------------------------------------------------------------------------
// mch_hdg: heading in whole degrees
// Folds the vector into one octant, then binary-searches the whole-degree
// sine and cosine tables with one narrow multiplier and a wide accumulator.
// ----------------------------------------------------------------------------
module mch_hdg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [mch_pkg::CAL_W-1:0]  x,
  input  logic signed [mch_pkg::CAL_W-1:0]  y,
  output mch_pkg::hdg_rsp_t                 rsp
);
  import mch_pkg::*;

  logic [TAB_W-1:0] sin_tab [TAB_N];
  logic [TAB_W-1:0] cos_tab [TAB_N];

  for (genvar k = 0; k < TAB_N; k++) begin : g_tab
    localparam logic [TAB_W-1:0] SV = sin_q48(k);
    localparam logic [TAB_W-1:0] CV = cos_q48(k);
    assign sin_tab[k] = SV;
    assign cos_tab[k] = CV;
  end

  logic [CAL_W-1:0]  ax, ay, v_in, u_in;
  logic [CAL_W-1:0]  v_r, u_r;
  logic [7:0]        base_in, base_r;
  logic              neg_in, neg_r, adj_in, adj_r, yneg_r, zero_r;
  logic [TAB_AW-1:0] lo_r, hi_r, f_r, mid, lo_new, hi_new;
  logic [1:0]        ph_r;
  logic              busy_r, done_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, term;
  logic [CAL_W-1:0]  mul_a;
  logic [TAB_HW-1:0] mul_b;
  logic [CAL_W+TAB_HW-1:0] prod;
  logic [TAB_W-1:0]  word;
  logic signed [9:0] a_val, d_val;

  always_comb begin
    ax = x[CAL_W-1] ? CAL_W'(-x) : x;
    ay = y[CAL_W-1] ? CAL_W'(-y) : y;
    if (!x[CAL_W-1]) begin
      if (ay <= ax) begin
        v_in = ay; u_in = ax; base_in = 8'd0;   neg_in = 1'b0; adj_in = 1'b0;
      end else begin
        v_in = ax; u_in = ay; base_in = 8'd90;  neg_in = 1'b1; adj_in = (ax != '0);
      end
    end else begin
      if (ay >= ax) begin
        v_in = ax; u_in = ay; base_in = 8'd90;  neg_in = 1'b0; adj_in = 1'b0;
      end else begin
        v_in = ay; u_in = ax; base_in = 8'd180; neg_in = 1'b1; adj_in = (ay != '0);
      end
    end
  end

  // Phases: v*cos low, v*cos high, minus u*sin low, minus u*sin high.
  always_comb begin
    mid   = TAB_AW'((7'(lo_r) + 7'(hi_r)) >> 1);
    word  = ph_r[1] ? sin_tab[mid] : cos_tab[mid];
    mul_a = ph_r[1] ? u_r : v_r;
    mul_b = ph_r[0] ? word[TAB_W-1:TAB_HW] : word[TAB_HW-1:0];
    prod  = (CAL_W+TAB_HW)'(mul_a) * (CAL_W+TAB_HW)'(mul_b);
    term  = ph_r[0] ? $signed(ACC_W'(prod) << TAB_HW) : $signed(ACC_W'(prod));
    case (ph_r)
      2'd0:    acc_nxt = term;
      2'd1:    acc_nxt = acc_r + term;
      default: acc_nxt = acc_r - term;
    endcase
    lo_new = acc_nxt[ACC_W-1] ? lo_r : mid;
    hi_new = acc_nxt[ACC_W-1] ? mid : hi_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ph_r <= '0;
        if ((x == '0 && y == '0) || v_in == u_in) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        ph_r <= ph_r + 1'b1;
        if (ph_r == 2'd3 && (hi_new - lo_new) == TAB_AW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= v_in;
      u_r    <= u_in;
      base_r <= base_in;
      neg_r  <= neg_in;
      adj_r  <= adj_in;
      yneg_r <= y[CAL_W-1];
      zero_r <= (x == '0 && y == '0);
      lo_r   <= '0;
      hi_r   <= TAB_AW'(TAB_N);
      f_r    <= (v_in == u_in) ? TAB_AW'(45) : '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      if (ph_r == 2'd3) begin
        lo_r <= lo_new;
        hi_r <= hi_new;
        f_r  <= lo_new;
      end
    end
  end

  always_comb begin
    if (neg_r) begin
      a_val = $signed({2'b00, base_r}) - $signed({4'b0000, f_r})
              - $signed({9'd0, adj_r});
    end else begin
      a_val = $signed({2'b00, base_r}) + $signed({4'b0000, f_r});
    end
    d_val = yneg_r ? -a_val : a_val;
  end

  assign rsp.done = done_r;
  assign rsp.deg  = zero_r ? '0 : d_val[HDG_W-1:0];

endmodule

// ===== rtl/magnetometer_calibrated_heading_top.sv =====
// ----------------------------------------------------------------------------
// magnetometer_calibrated_heading_top: hard-iron calibration and heading
// Scales raw samples to milligauss, tracks per-axis extremes, recenters and
// rescales axes over the span threshold, gives the heading in whole degrees.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_ready   status_byte, raw_x, raw_y, raw_z
//   out_     output     out_valid/out_ready cal_x, cal_y, cal_z, heading
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// An item without new data (low status nibble zero) repeats the last result.
// An item with new data goes through each axis in turn: the milligauss
// scaling (a reciprocal multiply), the extreme update and the offset; an
// axis whose span is above the threshold adds one pass of the shared
// divider. The heading search follows and skips the table search when x
// and y are both zero or of equal magnitude. Reset is synchronous and
// active low. The input is not ready while an item is worked on; a
// finished result waits until the output register is free, and the next
// transfer is taken once the result has been loaded there.
module magnetometer_calibrated_heading_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_status_byte,
  input  logic signed [mch_pkg::RAW_W-1:0]     in_raw_x,
  input  logic signed [mch_pkg::RAW_W-1:0]     in_raw_y,
  input  logic signed [mch_pkg::RAW_W-1:0]     in_raw_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mch_pkg::CAL_W-1:0]     out_cal_x,
  output logic signed [mch_pkg::CAL_W-1:0]     out_cal_y,
  output logic signed [mch_pkg::CAL_W-1:0]     out_cal_z,
  output logic signed [mch_pkg::HDG_W-1:0]     out_heading,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mch_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mch_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import mch_pkg::*;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SCL  = 4'd1;  // milligauss scaling
  localparam logic [3:0] ST_MM   = 4'd3;  // update running extremes
  localparam logic [3:0] ST_CAL  = 4'd4;  // offset, span and rescale start
  localparam logic [3:0] ST_CALW = 4'd5;
  localparam logic [3:0] ST_HDG  = 4'd6;
  localparam logic [3:0] ST_HDGW = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0]  state_r;
  logic [1:0]  axis_r;
  logic        neg_r;

  logic [SPAN_W-1:0]  min_span_r;
  logic [OSPAN_W-1:0] out_span_r;

  logic signed [RAW_W-1:0] raw_r [3];
  logic [MM_W-1:0]         min_r [3];
  logic [MM_W-1:0]         max_r [3];
  logic signed [CAL_W-1:0] cal_r [3];
  logic signed [HDG_W-1:0] hdg_r;
  logic signed [CAL_W-1:0] v_r;

  logic signed [CAL_W-1:0] o_x_r, o_y_r, o_z_r;
  logic signed [HDG_W-1:0] o_h_r;
  logic                    out_valid_r;

  div_req_t div_req;
  div_rsp_t div_rsp;
  hdg_rsp_t hdg_rsp;
  logic     hdg_start;

  logic signed [RAW_W-1:0] raw_sel;
  logic [RAW_W-1:0]        raw_mag;
  logic [SCL_PW-1:0]       scl_prod;
  logic [CAL_W-1:0]        scl_mag;
  logic signed [CAL_W-1:0] v_scl;
  logic signed [CAL_W-1:0] q_signed;
  logic [MM_W-1:0]         v_ext, mn_cur, mx_cur, mn_new, mx_new;
  logic signed [MM_W:0]    span16, sum16, off16, diff16;
  logic [MM_W-1:0]         dmag;
  logic                    do_scale;
  logic                    out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  mch_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  mch_hdg u_hdg (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hdg_start),
    .x     (cal_r[0]),
    .y     (cal_r[1]),
    .rsp   (hdg_rsp)
  );

  always_comb begin
    // Milligauss scaling works on the magnitude; the sign is put back after.
    // The multiply by the rounded-up reciprocal gives the truncated quotient
    // exactly over the whole 16-bit input range.
    raw_sel  = raw_r[axis_r];
    raw_mag  = raw_sel[RAW_W-1] ? RAW_W'(-raw_sel) : raw_sel;
    scl_prod = SCL_PW'(raw_mag) * SCL_PW'(SCALE_RECIP);
    scl_mag  = scl_prod[SCALE_SHIFT +: CAL_W];
    v_scl    = raw_sel[RAW_W-1] ? CAL_W'(-scl_mag) : scl_mag;
    q_signed = neg_r ? CAL_W'(-div_rsp.quotient[CAL_W-1:0])
                     : div_rsp.quotient[CAL_W-1:0];

    v_ext  = {v_r[CAL_W-1], v_r};
    mn_cur = min_r[axis_r];
    mx_cur = max_r[axis_r];
    mn_new = ($signed(v_ext) < $signed(mn_cur)) ? v_ext : mn_cur;
    mx_new = ($signed(v_ext) > $signed(mx_cur)) ? v_ext : mx_cur;

    // Midpoint truncated toward zero and the signed distance from it.
    span16   = $signed({mx_cur[MM_W-1], mx_cur}) - $signed({mn_cur[MM_W-1], mn_cur});
    sum16    = $signed({mx_cur[MM_W-1], mx_cur}) + $signed({mn_cur[MM_W-1], mn_cur});
    off16    = (sum16 + $signed({15'd0, sum16[MM_W]})) >>> 1;
    diff16   = $signed({{2{v_r[CAL_W-1]}}, v_r}) - off16;
    dmag     = diff16[MM_W] ? MM_W'(-diff16) : diff16[MM_W-1:0];
    do_scale = !span16[MM_W] && (span16[MM_W-1:0] > {1'b0, min_span_r});

    // The shared divider only serves the rescaling by the measured span.
    div_req.start    = (state_r == ST_CAL) && do_scale;
    div_req.dividend = DIV_NW'(dmag) * DIV_NW'(out_span_r);
    div_req.divisor  = span16[DIV_DW-1:0];
    hdg_start = (state_r == ST_HDG);
  end

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_span_r <= MIN_SPAN_RESET;
      out_span_r <= OUT_SPAN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_SPAN: min_span_r <= cfg_data[SPAN_W-1:0];
        CFG_OUT_SPAN: out_span_r <= cfg_data[OSPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, calibration state and the last result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= MIN_RESET;
        max_r[i] <= MAX_RESET;
        cal_r[i] <= '0;
      end
      hdg_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            axis_r  <= '0;
            state_r <= ((in_status_byte[3:0] & NEW_DATA_MASK) == 4'h0) ? ST_OUT : ST_SCL;
          end
        end
        ST_SCL: begin
          state_r <= ST_MM;
        end
        ST_MM: begin
          min_r[axis_r] <= mn_new;
          max_r[axis_r] <= mx_new;
          state_r       <= ST_CAL;
        end
        ST_CAL: begin
          if (do_scale) begin
            state_r <= ST_CALW;
          end else begin
            cal_r[axis_r] <= v_r;
            axis_r        <= axis_r + 1'b1;
            state_r       <= (axis_r == 2'd2) ? ST_HDG : ST_SCL;
          end
        end
        ST_CALW: begin
          if (div_rsp.done) begin
            cal_r[axis_r] <= q_signed;
            axis_r        <= axis_r + 1'b1;
            state_r       <= (axis_r == 2'd2) ? ST_HDG : ST_SCL;
          end
        end
        ST_HDG: begin
          state_r <= ST_HDGW;
        end
        ST_HDGW: begin
          if (hdg_rsp.done) begin
            hdg_r   <= hdg_rsp.deg;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw_r[0] <= in_raw_x;
      raw_r[1] <= in_raw_y;
      raw_r[2] <= in_raw_z;
    end
    if (state_r == ST_CAL) begin
      neg_r <= diff16[MM_W];
    end
    if (state_r == ST_SCL) begin
      v_r <= v_scl;
    end
    if (out_load) begin
      o_x_r <= cal_r[0];
      o_y_r <= cal_r[1];
      o_z_r <= cal_r[2];
      o_h_r <= hdg_r;
    end
  end

  // Output register: holds the result until the transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_cal_x   = o_x_r;
  assign out_cal_y   = o_y_r;
  assign out_cal_z   = o_z_r;
  assign out_heading = o_h_r;

endmodule

// ===== verif/tb_magnetometer_calibrated_heading_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calibrated heading block regression
// Drives status and raw axis samples through the valid/ready channels with
// random idling, predicts each result from its own model of the extreme
// tracking, recentring, rescaling and heading search, and compares in order.
// ----------------------------------------------------------------------------
module tb_magnetometer_calibrated_heading_top;
  import mch_pkg::*;

  // An index that names no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd7;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic signed [CAL_W-1:0] x, y, z;
    logic signed [HDG_W-1:0] deg;
  } heading_result_t;

  // Scoreboard: keeps its own copy of the registers and the running extremes,
  // and queues the result every accepted sample should produce.
  class heading_scoreboard;
    int min_span, out_span;
    int lo[3], hi[3];
    heading_result_t last_res;
    heading_result_t expected_q[$];
    longint sin_tab[45], cos_tab[45];
    int errors, checked, fresh_count, repeat_count, scaled_count;

    function new();
      real ang;
      min_span = MIN_SPAN_RESET;
      out_span = OUT_SPAN_RESET;
      for (int a = 0; a < 3; a++) begin
        lo[a] = 10000;
        hi[a] = -10000;
      end
      last_res = '{x: 0, y: 0, z: 0, deg: 0};
      for (int k = 0; k < 45; k++) begin
        ang = k * 3.14159265358979323846 / 180.0;
        sin_tab[k] = longint'($floor($sin(ang) * (2.0 ** 48)));
        cos_tab[k] = longint'($floor($cos(ang) * (2.0 ** 48)));
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_MIN_SPAN) min_span = data[SPAN_W-1:0];
      else if (idx == CFG_OUT_SPAN) out_span = data[OSPAN_W-1:0];
    endfunction

    // Whole degrees below atan(v/u), for 0 <= v <= u and u > 0.
    function int octant_deg(longint v, longint u);
      int f;
      f = 0;
      if (v == u) return 45;
      for (int k = 1; k <= 44; k++)
        if (v * cos_tab[k] >= u * sin_tab[k]) f = k;
      return f;
    endfunction

    function int heading_of(int x, int y);
      longint ax, ay;
      int a;
      if (x == 0 && y == 0) return 0;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (x >= 0) begin
        if (ay <= ax) a = octant_deg(ay, ax);
        else a = 90 - octant_deg(ax, ay) - ((ax == 0) ? 0 : 1);
      end else begin
        if (ay >= ax) a = 90 + octant_deg(ax, ay);
        else a = 180 - octant_deg(ay, ax) - ((ay == 0) ? 0 : 1);
      end
      return (y < 0) ? -a : a;
    endfunction

    function int recenter(int a, int v);
      int span, mid;
      if (v < lo[a]) lo[a] = v;
      if (v > hi[a]) hi[a] = v;
      span = hi[a] - lo[a];
      mid = (hi[a] + lo[a]) / 2;
      if (span > min_span && span > 0) begin
        scaled_count++;
        return ((v - mid) * out_span) / span;
      end
      return v;
    endfunction

    function void note_input(logic [7:0] status, logic signed [RAW_W-1:0] rx,
                             logic signed [RAW_W-1:0] ry, logic signed [RAW_W-1:0] rz);
      int cx, cy, cz;
      if (status[3:0] != 4'h0) begin
        fresh_count++;
        cx = recenter(0, (int'(rx) * 1000) / 6842);
        cy = recenter(1, (int'(ry) * 1000) / 6842);
        cz = recenter(2, (int'(rz) * 1000) / 6842);
        last_res.x = cx[CAL_W-1:0];
        last_res.y = cy[CAL_W-1:0];
        last_res.z = cz[CAL_W-1:0];
        last_res.deg = HDG_W'(heading_of(cx, cy));
      end else begin
        repeat_count++;
      end
      expected_q.push_back(last_res);
    endfunction

    function void check_result(heading_result_t got);
      heading_result_t exp;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: x=%0d y=%0d z=%0d deg=%0d",
                 $time, got.x, got.y, got.z, got.deg);
        return;
      end
      exp = expected_q.pop_front();
      if (got.x !== exp.x) begin
        errors++;
        $display("%0t: cal_x expected %0d actual %0d", $time, exp.x, got.x);
      end
      if (got.y !== exp.y) begin
        errors++;
        $display("%0t: cal_y expected %0d actual %0d", $time, exp.y, got.y);
      end
      if (got.z !== exp.z) begin
        errors++;
        $display("%0t: cal_z expected %0d actual %0d", $time, exp.z, got.z);
      end
      if (got.deg !== exp.deg) begin
        errors++;
        $display("%0t: heading expected %0d actual %0d", $time, exp.deg, got.deg);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [7:0] in_status_byte;
  logic signed [RAW_W-1:0] in_raw_x, in_raw_y, in_raw_z;
  logic out_valid, out_ready;
  logic signed [CAL_W-1:0] out_cal_x, out_cal_y, out_cal_z;
  logic signed [HDG_W-1:0] out_heading;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  heading_scoreboard sb;
  bit idle_on;        // random idling on both sides
  int hold_left;      // long receiver hold-off, counted by the receiver process
  int stall_left;
  int quiet_cycles;

  magnetometer_calibrated_heading_top uut (.*);

  // 2 ns clock.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver: random stall bursts, plus the long hold-off when one is asked.
  initial begin
    out_ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result monitor and watchdog. The watchdog counts cycles in which no
  // transfer happens on any channel; the long hold-off stays well below it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result('{x: out_cal_x, y: out_cal_y, z: out_cal_z, deg: out_heading});
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // One sample over the input channel; the scoreboard sees it on transfer.
  task automatic send_sample(logic [7:0] status, logic signed [RAW_W-1:0] rx,
                             logic signed [RAW_W-1:0] ry, logic signed [RAW_W-1:0] rz);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_status_byte <= status;
    in_raw_x <= rx;
    in_raw_y <= ry;
    in_raw_z <= rz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(status, rx, ry, rz);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Register write; only issued once the block has delivered everything.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // Random sample: mostly fresh data, with a spread of magnitudes so that the
  // extremes grow gradually and small headings near the axes show up too.
  task automatic random_sample();
    logic [7:0] st;
    logic signed [RAW_W-1:0] r[3];
    st = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) != 0 && st[3:0] == 4'h0) st[$urandom_range(0, 3)] = 1'b1;
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(0, 3))
        0: r[a] = 16'($urandom_range(0, 65535));
        1: r[a] = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
        2: r[a] = $signed(16'($urandom_range(0, 100))) - 16'sd50;
        default: r[a] = $signed(16'($urandom_range(0, 20000))) - 16'sd10000;
      endcase
    end
    send_sample(st, r[0], r[1], r[2]);
  endtask

  initial begin
    sb = new();
    idle_on = 1'b1;
    hold_left = 0;
    quiet_cycles = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_status_byte <= '0;
    in_raw_x <= '0;
    in_raw_y <= '0;
    in_raw_z <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at reset register values. The first fresh sample has a span
    // at or below the threshold, so it passes through scaled only.
    send_sample(8'h00, 16'sd1234, 16'sd5, -16'sd7);        // no new data: zeros
    send_sample(8'h01, 16'sd0, 16'sd0, 16'sd32767);        // zero x and y
    send_sample(8'h02, -16'sd3000, 16'sd0, 16'sd0);        // negative x, zero y
    send_sample(8'hF0, 16'sd100, 16'sd100, 16'sd100);      // high nibble only
    send_sample(8'h04, 16'sd2000, 16'sd2000, -16'sd32768); // raw input at exactly 45 degrees
    send_sample(8'h08, 16'sd0, -16'sd2000, 16'sd0);        // raw input straight down
    send_sample(8'hFF, 16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(8'h0F, -16'sd32768, -16'sd32768, -16'sd32768);
    send_sample(8'h10, -16'sd32768, 16'sd1, 16'sd1);
    send_sample(8'h81, -16'sd2000, 16'sd2000, 16'sd0);     // raw input at 135 degrees
    send_sample(8'h03, -16'sd2000, -16'sd2000, 16'sd5);
    send_sample(8'h05, 16'sd0, 16'sd3000, -16'sd1);
    send_sample(8'h20, 16'sd0, 16'sd0, 16'sd0);
    send_sample(8'h06, 16'sd7, -16'sd6, 16'sd6841);
    send_sample(8'h09, 16'sd6842, -16'sd6842, 16'sd6843);
    send_sample(8'h0A, 16'sd1, 16'sd0, 16'sd0);

    // Lowest threshold and highest output span; the receiver holds off for
    // a long stretch while samples keep coming, so the block backs up.
    write_reg(CFG_MIN_SPAN, 16'd0);
    write_reg(CFG_OUT_SPAN, 16'd1023);
    hold_left = 400;
    repeat (290) random_sample();

    // A mask test: all ones leaves the threshold at its largest value, so
    // nothing gets rescaled. The sender then pauses until all results are in.
    write_reg(CFG_MIN_SPAN, 16'hFFFF);
    write_reg(CFG_OUT_SPAN, 16'hFC00);
    repeat (140) random_sample();
    drain();
    repeat (140) random_sample();

    // Top of the threshold range with a zero output span, and a write to an
    // index that names no register.
    write_reg(CFG_MIN_SPAN, 16'd9578);
    write_reg(CFG_OUT_SPAN, 16'd0);
    write_reg(CFG_UNUSED_IDX, 16'h1234);
    repeat (290) random_sample();

    write_reg(CFG_MIN_SPAN, 16'($urandom_range(0, 9578)));
    write_reg(CFG_OUT_SPAN, 16'($urandom_range(0, 1023)));
    repeat (290) random_sample();

    // Last stretch at full rate on both sides.
    write_reg(CFG_MIN_SPAN, 16'd300);
    write_reg(CFG_OUT_SPAN, 16'd800);
    idle_on = 1'b0;
    repeat (290) random_sample();

    drain();
    repeat (300) @(posedge clk);
    $display("Checked %0d results: %0d fresh samples, %0d repeats, %0d rescaled axes.",
             sb.checked, sb.fresh_count, sb.repeat_count, sb.scaled_count);
    $display("Register settings covered both threshold extremes and output spans 0 to 1023.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.expected_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mch_pkg.sv
rtl/mch_div.sv
rtl/mch_hdg.sv
rtl/magnetometer_calibrated_heading_top.sv
verif/tb_magnetometer_calibrated_heading_top.sv
